>>> rtl/assert_macros.svh
// Assertion macros used by the solver core RTL.
// In synthesis builds every macro expands to nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Checked on every clock edge outside reset.
`define QRS_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("qrs assertion failed");
// Checked on every clock edge, reset included.
`define QRS_ASSERT_ALL(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("qrs assertion failed");
`else
`define QRS_ASSERT(lbl, clk, rst, prop)
`define QRS_ASSERT_ALL(lbl, clk, prop)
`endif
`endif

>>> rtl/qrs_pkg.sv
// ----------------------------------------------------------------------------
// qrs_pkg
// Types and widths shared by the quadratic root solver pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package qrs_pkg;

  // Field widths of the coefficient and root beats.
  localparam int COEF_WIDTH = 16;
  localparam int ROOT_WIDTH = 32;
  localparam int OUT_FRAC   = 16;

  // Square root: digit pairs of the radicand and bits of the root.
  localparam int RAD_PAIRS  = COEF_WIDTH + 1;
  localparam int ROOT_BITS  = RAD_PAIRS + OUT_FRAC;
  localparam int DISC_WIDTH = 2 * COEF_WIDTH + 2;
  localparam int MAG_WIDTH  = 2 * RAD_PAIRS;
  localparam int REM_WIDTH  = ROOT_BITS + 3;

  // Division: numerator magnitude and divisor magnitude.
  localparam int NUM_WIDTH  = COEF_WIDTH + OUT_FRAC + 2;
  localparam int DEN_WIDTH  = COEF_WIDTH + 1;

  typedef enum logic [1:0] {
    KIND_TWO_REAL  = 2'd0,
    KIND_REPEATED  = 2'd1,
    KIND_COMPLEX   = 2'd2,
    KIND_ZERO_LEAD = 2'd3
  } kind_t;

  typedef struct packed {
    logic signed [COEF_WIDTH-1:0] coef_a;
    logic signed [COEF_WIDTH-1:0] coef_b;
    logic signed [COEF_WIDTH-1:0] coef_c;
  } coef_t;

  typedef struct packed {
    kind_t                        root_kind;
    logic signed [ROOT_WIDTH-1:0] first_value;
    logic signed [ROOT_WIDTH-1:0] second_value;
    logic                         saturated;
  } root_t;

endpackage

`default_nettype wire

>>> rtl/quadratic_root_solver_core.sv
// Registers in order: products, discriminant, square root stages, numerator,
// sign, divider stages, output. Throughput: one beat per cycle while not stalled;
// the square root and both dividers are pipelined, one result bit per stage.
// A stalled result beat freezes the whole pipeline and stalls the input.
// Reset clears every valid bit; payload registers are not reset.
// ----------------------------------------------------------------------------
// quadratic_root_solver_core
// Solves a*x^2 + b*x + c = 0 for Q8.8 coefficients, giving Q16.16 roots.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module quadratic_root_solver_core (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            coef_valid,
  output logic                 coef_stall,
  input  wire qrs_pkg::coef_t  coefs,
  output logic                 root_valid,
  input  wire logic            root_stall,
  output qrs_pkg::root_t       roots
);

  localparam int CW   = qrs_pkg::COEF_WIDTH;
  localparam int RW   = qrs_pkg::ROOT_WIDTH;
  localparam int SQ   = qrs_pkg::ROOT_BITS;
  localparam int DSW  = qrs_pkg::DISC_WIDTH;
  localparam int MW   = qrs_pkg::MAG_WIDTH;
  localparam int REM  = qrs_pkg::REM_WIDTH;
  localparam int NW   = qrs_pkg::NUM_WIDTH;
  localparam int DW   = qrs_pkg::DEN_WIDTH;
  localparam int NS   = NW + 1;
  localparam int CMPW = ((NW > RW) ? NW : RW) + 1;

  typedef struct packed {
    qrs_pkg::kind_t       kind;
    logic signed [CW-1:0] a;
    logic signed [CW-1:0] b;
  } side_t;

  typedef struct packed {
    qrs_pkg::kind_t kind;
    logic           neg1;
    logic           neg2;
  } div_side_t;

  // The pipeline moves as one unless a result beat waits at the output.
  logic adv;
  assign adv        = !(root_valid && root_stall);
  assign coef_stall = !adv;

  // Stage 1: the two products of the discriminant.
  logic                   s1_valid;
  logic signed [2*CW-1:0] s1_bb;
  logic signed [2*CW-1:0] s1_ac;
  logic signed [CW-1:0]   s1_a;
  logic signed [CW-1:0]   s1_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= coef_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_bb <= coefs.coef_b * coefs.coef_b;
      s1_ac <= coefs.coef_a * coefs.coef_c;
      s1_a  <= coefs.coef_a;
      s1_b  <= coefs.coef_b;
    end
  end

  // Stage 2: discriminant, its class and its magnitude.
  logic signed [DSW-1:0] disc;
  qrs_pkg::kind_t        kind_c;
  logic                  sq_vld  [0:SQ];
  side_t                 sq_side [0:SQ];
  logic [MW-1:0]         sq_mag  [0:SQ];
  logic [REM-1:0]        sq_rem  [1:SQ];
  logic [SQ-1:0]         sq_root [1:SQ];

  assign disc = DSW'(s1_bb) - (DSW'(s1_ac) <<< 2);

  always_comb begin
    if (s1_a == '0) begin
      kind_c = qrs_pkg::KIND_ZERO_LEAD;
    end else if (disc == '0) begin
      kind_c = qrs_pkg::KIND_REPEATED;
    end else if (disc[DSW-1]) begin
      kind_c = qrs_pkg::KIND_COMPLEX;
    end else begin
      kind_c = qrs_pkg::KIND_TWO_REAL;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_vld[0] <= 1'b0;
    end else if (adv) begin
      sq_vld[0] <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sq_side[0] <= '{kind: kind_c, a: s1_a, b: s1_b};
      sq_mag[0]  <= disc[DSW-1] ? MW'(-disc) : MW'(disc);
    end
  end

  // Square root, one root bit per stage, two radicand bits brought down.
  for (genvar k = 0; k < SQ; k++) begin : g_sq
    localparam int P = qrs_pkg::RAD_PAIRS - 1 - k;
    logic [REM-1:0] rem_prev;
    logic [SQ-1:0]  root_prev;
    logic [1:0]     pair;
    logic [REM-1:0] rem_sh;
    logic [REM-1:0] trial;
    logic           ge;

    if (k == 0) begin : g_first
      assign rem_prev  = '0;
      assign root_prev = '0;
    end else begin : g_rest
      assign rem_prev  = sq_rem[k];
      assign root_prev = sq_root[k];
    end

    if (P >= 0) begin : g_pair
      assign pair = sq_mag[k][2*P+1:2*P];
    end else begin : g_frac
      assign pair = 2'b00;
    end

    assign rem_sh = {rem_prev[REM-3:0], pair};
    assign trial  = REM'({root_prev, 2'b01});
    assign ge     = rem_sh >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        sq_vld[k+1] <= 1'b0;
      end else if (adv) begin
        sq_vld[k+1] <= sq_vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        sq_rem[k+1]  <= ge ? rem_sh - trial : rem_sh;
        sq_root[k+1] <= {root_prev[SQ-2:0], ge};
        sq_mag[k+1]  <= sq_mag[k];
        sq_side[k+1] <= sq_side[k];
      end
    end
  end

  // Numerator stage: pick the two numerators for the result kind.
  logic signed [NS-1:0] base_c;
  logic signed [NS-1:0] rt_c;
  logic                 p1_valid;
  logic signed [NS-1:0] p1_n1;
  logic signed [NS-1:0] p1_n2;
  logic signed [CW-1:0] p1_a;
  qrs_pkg::kind_t       p1_kind;

  assign base_c = -(NS'(sq_side[SQ].b) <<< qrs_pkg::OUT_FRAC);
  assign rt_c   = NS'($signed({1'b0, sq_root[SQ]}));

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
    end else if (adv) begin
      p1_valid <= sq_vld[SQ];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p1_a    <= sq_side[SQ].a;
      p1_kind <= sq_side[SQ].kind;
      case (sq_side[SQ].kind)
        qrs_pkg::KIND_TWO_REAL: begin
          p1_n1 <= base_c + rt_c;
          p1_n2 <= base_c - rt_c;
        end
        qrs_pkg::KIND_COMPLEX: begin
          p1_n1 <= base_c;
          p1_n2 <= rt_c;
        end
        default: begin
          p1_n1 <= base_c;
          p1_n2 <= base_c;
        end
      endcase
    end
  end

  // Sign stage: magnitudes for the dividers and the quotient signs.
  logic signed [CW:0]   a_ext;
  logic signed [CW:0]   a_abs;
  logic                 dv_vld  [0:NW];
  div_side_t            dv_side [0:NW];
  logic [NW-1:0]        p2_m1;
  logic [NW-1:0]        p2_m2;
  logic [DW-1:0]        p2_den;

  assign a_ext = (CW+1)'(p1_a);
  assign a_abs = p1_a[CW-1] ? -a_ext : a_ext;

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_vld[0] <= 1'b0;
    end else if (adv) begin
      dv_vld[0] <= p1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p2_m1      <= p1_n1[NS-1] ? NW'(-p1_n1) : NW'(p1_n1);
      p2_m2      <= p1_n2[NS-1] ? NW'(-p1_n2) : NW'(p1_n2);
      p2_den     <= {a_abs[CW-1:0], 1'b0};
      dv_side[0] <= '{kind: p1_kind,
                      neg1: p1_n1[NS-1] ^ p1_a[CW-1],
                      neg2: p1_n2[NS-1] ^ p1_a[CW-1]};
    end
  end

  // Two dividers share the divisor; the side band travels next to them.
  logic [NW-1:0] quo1;
  logic [NW-1:0] quo2;

  qrs_div_pipe u_div1 (
    .clk (clk),
    .adv (adv),
    .num (p2_m1),
    .den (p2_den),
    .quo (quo1)
  );

  qrs_div_pipe u_div2 (
    .clk (clk),
    .adv (adv),
    .num (p2_m2),
    .den (p2_den),
    .quo (quo2)
  );

  for (genvar j = 0; j < NW; j++) begin : g_dv
    always_ff @(posedge clk) begin
      if (rst) begin
        dv_vld[j+1] <= 1'b0;
      end else if (adv) begin
        dv_vld[j+1] <= dv_vld[j];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        dv_side[j+1] <= dv_side[j];
      end
    end
  end

  // Apply the sign and clamp to the root range; the top bit flags a clamp.
  function automatic logic [RW:0] clamp_root(input logic [NW-1:0] q, input logic neg);
    logic [CMPW-1:0] qe;
    logic [CMPW-1:0] half;
    logic [CMPW-1:0] v;
    logic            sat;
    qe   = CMPW'(q);
    half = CMPW'(1) << (RW - 1);
    sat  = 1'b0;
    v    = qe;
    if (neg) begin
      if (qe > half) begin
        v   = half;
        sat = 1'b1;
      end
      v = -v;
    end else if (qe > half - CMPW'(1)) begin
      v   = half - CMPW'(1);
      sat = 1'b1;
    end
    return {sat, v[RW-1:0]};
  endfunction

  logic [RW:0] cl1;
  logic [RW:0] cl2;

  assign cl1 = clamp_root(quo1, dv_side[NW].neg1);
  assign cl2 = clamp_root(quo2, dv_side[NW].neg2);

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      root_valid <= 1'b0;
    end else if (adv) begin
      root_valid <= dv_vld[NW];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      roots.root_kind <= dv_side[NW].kind;
      if (dv_side[NW].kind == qrs_pkg::KIND_ZERO_LEAD) begin
        roots.first_value  <= '0;
        roots.second_value <= '0;
        roots.saturated    <= 1'b0;
      end else begin
        roots.first_value  <= $signed(cl1[RW-1:0]);
        roots.second_value <= $signed(cl2[RW-1:0]);
        roots.saturated    <= cl1[RW] | cl2[RW];
      end
    end
  end

  // A degenerate equation never reports roots or a clamp.
  `QRS_ASSERT(a_zero_lead_clear, clk, rst,
    (root_valid && roots.root_kind == qrs_pkg::KIND_ZERO_LEAD) |->
      (roots.first_value == '0 && roots.second_value == '0 && !roots.saturated))
  // A repeated root shows the same value in both fields.
  `QRS_ASSERT(a_repeated_equal, clk, rst,
    (root_valid && roots.root_kind == qrs_pkg::KIND_REPEATED) |->
      (roots.first_value == roots.second_value))
  // Reset empties the output stage.
  `QRS_ASSERT_ALL(a_reset_empty, clk, rst |=> !root_valid)
  // A zero coefficient a stays classified as degenerate through the root stages.
  `QRS_ASSERT(a_kind_follows_a, clk, rst,
    (sq_vld[SQ] && sq_side[SQ].a == '0) |-> (sq_side[SQ].kind == qrs_pkg::KIND_ZERO_LEAD))

endmodule

`default_nettype wire

>>> rtl/qrs_div_pipe.sv
// ----------------------------------------------------------------------------
// qrs_div_pipe
// Pipelined restoring divider: one quotient bit per register stage.
// ----------------------------------------------------------------------------
`default_nettype none

module qrs_div_pipe (
  input  wire logic                           clk,
  input  wire logic                           adv,
  input  wire logic [qrs_pkg::NUM_WIDTH-1:0]  num,
  input  wire logic [qrs_pkg::DEN_WIDTH-1:0]  den,
  output logic      [qrs_pkg::NUM_WIDTH-1:0]  quo
);

  localparam int NW = qrs_pkg::NUM_WIDTH;
  localparam int DW = qrs_pkg::DEN_WIDTH;

  logic [NW-1:0] num_r [1:NW];
  logic [NW-1:0] quo_r [1:NW];
  logic [DW-1:0] rem_r [1:NW];
  logic [DW-1:0] den_r [1:NW];

  // Each stage brings down one numerator bit and tries one subtraction.
  for (genvar j = 0; j < NW; j++) begin : g_step
    logic [NW-1:0] num_in;
    logic [NW-1:0] quo_in;
    logic [DW-1:0] rem_in;
    logic [DW-1:0] den_in;
    logic [DW:0]   rem_sh;
    logic          ge;

    if (j == 0) begin : g_first
      assign num_in = num;
      assign quo_in = '0;
      assign rem_in = '0;
      assign den_in = den;
    end else begin : g_rest
      assign num_in = num_r[j];
      assign quo_in = quo_r[j];
      assign rem_in = rem_r[j];
      assign den_in = den_r[j];
    end

    assign rem_sh = {rem_in, num_in[NW-1]};
    assign ge     = rem_sh >= {1'b0, den_in};

    always_ff @(posedge clk) begin
      if (adv) begin
        num_r[j+1] <= {num_in[NW-2:0], 1'b0};
        quo_r[j+1] <= {quo_in[NW-2:0], ge};
        rem_r[j+1] <= ge ? DW'(rem_sh - {1'b0, den_in}) : DW'(rem_sh);
        den_r[j+1] <= den_in;
      end
    end
  end

  assign quo = quo_r[NW];

endmodule

`default_nettype wire
